// ===== rtl/exfwd_pkg.sv =====
// Shared types and constants for the execute stage with operand forwarding.
package exfwd_pkg;

    localparam int XLEN      = 32;
    localparam int CTRL_W    = 16;
    localparam int REG_IDX_W = 5;
    localparam int SHAMT_W   = 5;

    // Packed request widths, padded to whole bytes
    localparam int IN_DATA_W  = 240;
    localparam int OUT_DATA_W = 120;

    // Control word fields
    localparam int CTRL_OP_LSB  = 12;
    localparam int CTRL_OP_W    = 4;
    localparam int CTRL_IMM_BIT = 8;

    // ALU operation codes; codes 11 to 15 fall back to add
    typedef enum logic [CTRL_OP_W-1:0] {
        ALU_ADD  = 4'd0,
        ALU_SUB  = 4'd1,
        ALU_SLL  = 4'd2,
        ALU_SLT  = 4'd3,
        ALU_LTU  = 4'd4,
        ALU_XOR  = 4'd5,
        ALU_SRL  = 4'd6,
        ALU_SRA  = 4'd7,
        ALU_OR   = 4'd8,
        ALU_AND  = 4'd9,
        ALU_PASS = 4'd10
    } t_alu_op;

endpackage

// ===== rtl/exfwd_alu.sv =====
// Combinational RV32 integer ALU.
module exfwd_alu
    import exfwd_pkg::*;
(
    input  logic [CTRL_OP_W-1:0] i_op,
    input  logic [XLEN-1:0]      i_a,
    input  logic [XLEN-1:0]      i_b,
    output logic [XLEN-1:0]      o_result
);

    logic [SHAMT_W-1:0] w_shamt;

    assign w_shamt = i_b[SHAMT_W-1:0];

    always_comb begin
        case (t_alu_op'(i_op))
            ALU_SUB:  o_result = i_a - i_b;
            ALU_SLL:  o_result = i_a << w_shamt;
            ALU_SLT:  o_result = {{(XLEN-1){1'b0}}, ($signed(i_a) < $signed(i_b))};
            ALU_LTU:  o_result = {{(XLEN-1){1'b0}}, (i_a < i_b)};
            ALU_XOR:  o_result = i_a ^ i_b;
            ALU_SRL:  o_result = i_a >> w_shamt;
            ALU_SRA:  o_result = XLEN'($signed(i_a) >>> w_shamt);
            ALU_OR:   o_result = i_a | i_b;
            ALU_AND:  o_result = i_a & i_b;
            ALU_PASS: o_result = i_b;
            default:  o_result = i_a + i_b;
        endcase
    end

endmodule

// ===== rtl/execute_stage_alu_forwarding_unit.sv =====
// Top level of the execute stage: input register, forwarding, ALU, result register.
//
// Execute stage of a five-stage RV32 pipeline with operand forwarding. Each
// request carries one instruction with its register-file operands and the
// EX/MEM and MEM/WB write-back state; each operand is taken from EX/MEM if
// its source index matches a nonzero EX/MEM destination, else from MEM/WB on
// a nonzero match, else from the register file. Control bit 8 swaps the right
// operand for the immediate; the forwarded second operand leaves as store
// data. The stage takes one request every clock cycle while its ready is
// high; each request passes through the input register, then the forwarding
// muxes and ALU feed the result register. Both registers are held while the
// output is stalled, and ready passes back from the output combinationally
// through both stages, so a full pipe still takes a new request in the cycle
// the waiting result is taken. There is no architectural state: reset only
// clears the two valid flags.
module execute_stage_alu_forwarding_unit
    import exfwd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Request side
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata, low bit up: pc_value[31:0], control_word[47:32], src1_value[79:48],
    // src2_value[111:80], immediate[143:112], dest_reg[148:144],
    // src1_reg[153:149], src2_reg[158:154], exmem_write_dest[163:159],
    // memwb_write_dest[168:164], exmem_value[200:169], memwb_value[232:201],
    // zero pad[239:233]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // Result side
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // tdata, low bit up: ctrl_word_out[15:0], zero_flag[16], alu_result[48:17],
    // store_data[80:49], dest_out[85:81], pc_out[117:86], zero pad[119:118]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    // Input register
    logic                 r_in_valid;
    logic [XLEN-1:0]      r_pc;
    logic [CTRL_W-1:0]    r_ctrl;
    logic [XLEN-1:0]      r_src1_val;
    logic [XLEN-1:0]      r_src2_val;
    logic [XLEN-1:0]      r_imm;
    logic [REG_IDX_W-1:0] r_dest;
    logic [REG_IDX_W-1:0] r_src1_reg;
    logic [REG_IDX_W-1:0] r_src2_reg;
    logic [REG_IDX_W-1:0] r_exmem_dest;
    logic [REG_IDX_W-1:0] r_memwb_dest;
    logic [XLEN-1:0]      r_exmem_val;
    logic [XLEN-1:0]      r_memwb_val;

    // Result register
    logic                 r_out_valid;
    logic [CTRL_W-1:0]    r_out_ctrl;
    logic                 r_out_zero;
    logic [XLEN-1:0]      r_out_alu;
    logic [XLEN-1:0]      r_out_store;
    logic [REG_IDX_W-1:0] r_out_dest;
    logic [XLEN-1:0]      r_out_pc;

    logic                 n_in_valid;
    logic                 n_out_valid;

    logic                 w_out_ready;
    logic                 w_in_ready;
    logic                 w_in_take;
    logic                 w_out_load;

    logic                 w_ex_hit1, w_wb_hit1, w_ex_hit2, w_wb_hit2;
    logic [XLEN-1:0]      w_left;
    logic [XLEN-1:0]      w_store;
    logic [XLEN-1:0]      w_right;
    logic [XLEN-1:0]      w_alu_result;

    // Handshake: each stage advances when the one after it has room
    assign w_out_ready     = !r_out_valid || i_m_axis_tready;
    assign w_in_ready      = !r_in_valid || w_out_ready;
    assign o_s_axis_tready = w_in_ready;
    assign w_in_take       = i_s_axis_tvalid && w_in_ready;
    assign w_out_load      = r_in_valid && w_out_ready;

    assign n_in_valid  = w_in_ready ? i_s_axis_tvalid : r_in_valid;
    assign n_out_valid = w_out_ready ? r_in_valid : r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Unpack the request into the input register
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_pc         <= i_s_axis_tdata[31:0];
            r_ctrl       <= i_s_axis_tdata[47:32];
            r_src1_val   <= i_s_axis_tdata[79:48];
            r_src2_val   <= i_s_axis_tdata[111:80];
            r_imm        <= i_s_axis_tdata[143:112];
            r_dest       <= i_s_axis_tdata[148:144];
            r_src1_reg   <= i_s_axis_tdata[153:149];
            r_src2_reg   <= i_s_axis_tdata[158:154];
            r_exmem_dest <= i_s_axis_tdata[163:159];
            r_memwb_dest <= i_s_axis_tdata[168:164];
            r_exmem_val  <= i_s_axis_tdata[200:169];
            r_memwb_val  <= i_s_axis_tdata[232:201];
        end
    end

    // Forwarding: EX/MEM wins over MEM/WB, x0 never matches
    assign w_ex_hit1 = (r_exmem_dest != '0) && (r_exmem_dest == r_src1_reg);
    assign w_wb_hit1 = (r_memwb_dest != '0) && (r_memwb_dest == r_src1_reg);
    assign w_ex_hit2 = (r_exmem_dest != '0) && (r_exmem_dest == r_src2_reg);
    assign w_wb_hit2 = (r_memwb_dest != '0) && (r_memwb_dest == r_src2_reg);

    assign w_left  = w_ex_hit1 ? r_exmem_val : (w_wb_hit1 ? r_memwb_val : r_src1_val);
    assign w_store = w_ex_hit2 ? r_exmem_val : (w_wb_hit2 ? r_memwb_val : r_src2_val);
    assign w_right = r_ctrl[CTRL_IMM_BIT] ? r_imm : w_store;

    exfwd_alu u_alu (
        .i_op     (r_ctrl[CTRL_OP_LSB +: CTRL_OP_W]),
        .i_a      (w_left),
        .i_b      (w_right),
        .o_result (w_alu_result)
    );

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_ctrl  <= r_ctrl;
            r_out_zero  <= (w_alu_result == '0);
            r_out_alu   <= w_alu_result;
            r_out_store <= w_store;
            r_out_dest  <= r_dest;
            r_out_pc    <= r_pc;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_pc, r_out_dest, r_out_store,
                              r_out_alu, r_out_zero, r_out_ctrl};

    // A held request moves to the result register once there is room
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && w_out_ready |=> r_out_valid)
        else $error("request in input register did not advance");

    // Back-pressure only when the input register is occupied
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> r_in_valid && r_out_valid)
        else $error("request side stalled with room in the pipe");

    // Zero flag agrees with the registered result
    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_zero == (r_out_alu == '0)))
        else $error("zero flag disagrees with ALU result");

    // Register x0 is never forwarded, checked on the first operand
    a_x0_no_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && (r_src1_reg == '0) |-> (w_left == r_src1_val))
        else $error("x0 operand was forwarded");

endmodule
